// ===== sv/sfdl_pkg.sv =====
// Shared constants, types and register codes for the stereo feedback delay line.
package sfdl_pkg;

  localparam int HIST_DEPTH = 131072;
  localparam int ADDR_W     = $clog2(HIST_DEPTH);
  localparam int SAMPLE_W   = 16;
  localparam int FRAME_W    = 2 * SAMPLE_W;
  localparam int DELAY_W    = 17;
  localparam int GAIN_W     = 15;
  localparam int CFG_W      = 17;
  localparam int IDX_W      = 2;
  localparam int CMP_W      = ((ADDR_W > DELAY_W) ? ADDR_W : DELAY_W) + 1;

  localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(24000);
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(16384);
  localparam logic [GAIN_W-1:0]  GAIN_MAX    = GAIN_W'(32440);

  typedef enum logic [IDX_W-1:0] {
    REG_DELAY = 2'd0,
    REG_GAIN  = 2'd1
  } reg_idx_t;

  // Per-word control handed from the pipeline to each channel datapath
  typedef struct packed {
    logic              d_zero;    // delay of zero: feed the input itself
    logic              fwd_hit;   // read raced the previous write-back
    logic              hist_vld;  // history entry was written since reset
    logic [GAIN_W-1:0] gain;      // clamped feedback gain
  } chan_ctl_t;

endpackage

// ===== sv/sfdl_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module sfdl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-during-write to the same entry returns the old word
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/sfdl_chan.sv =====
// One channel datapath: tap select, unsigned Q0.15 gain multiply, round, add, saturate.
module sfdl_chan (
  input  logic [sfdl_pkg::SAMPLE_W-1:0] x,
  input  logic [sfdl_pkg::SAMPLE_W-1:0] rdata,
  input  logic [sfdl_pkg::SAMPLE_W-1:0] fwd,
  input  sfdl_pkg::chan_ctl_t           ctl,
  output logic [sfdl_pkg::SAMPLE_W-1:0] y
);

  localparam int SW = sfdl_pkg::SAMPLE_W;
  localparam int GW = sfdl_pkg::GAIN_W;
  localparam int PW = SW + GW + 1;
  localparam int QW = PW - GW;
  localparam int YW = QW + 1;

  localparam logic signed [PW-1:0] RND    = PW'(1) <<< (GW - 1);
  localparam logic signed [YW-1:0] SAT_HI = YW'((2 ** (SW - 1)) - 1);
  localparam logic signed [YW-1:0] SAT_LO = -SAT_HI - YW'(1);

  logic signed [SW-1:0] tap;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_rnd;
  logic signed [QW-1:0] scaled;
  logic signed [YW-1:0] sum;

  always_comb begin
    if (ctl.d_zero) begin
      tap = $signed(x);
    end else if (ctl.fwd_hit) begin
      tap = $signed(fwd);
    end else if (ctl.hist_vld) begin
      tap = $signed(rdata);
    end else begin
      tap = '0;
    end
  end

  assign prod     = PW'(tap) * $signed({1'b0, ctl.gain});
  assign prod_rnd = prod + RND;
  // floor shift, ties go toward plus infinity
  assign scaled   = QW'(prod_rnd >>> GW);
  assign sum      = YW'($signed(x)) + YW'(scaled);

  always_comb begin
    if (sum > SAT_HI) begin
      y = SW'(SAT_HI);
    end else if (sum < SAT_LO) begin
      y = SW'(SAT_LO);
    end else begin
      y = SW'(sum);
    end
  end

endmodule

// ===== sv/stereo_feedback_delay_line_top.sv =====
// Top level of the stereo feedback comb delay line: control, pipeline, history RAM.
//
//  channel   | dir | handshake                     | payload
//  ----------+-----+-------------------------------+------------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata [15:0] left_in, [31:16] right_in
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tdata [15:0] left_out, [31:16] right_out
//  cfg       | in  | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
//  One frame per cycle sustained while m_axis is ready; the d = 1 recurrence closes through one
//  multiply-add-saturate in stage A, fed from the last written word.
//  An accepted word is held in stage A, then in the output register that drives m_axis.
//  Reset (synchronous) clears pointer, wrap flag and valid bits and loads the config registers
//  with their defaults; history is not swept, unwritten entries read as zero via the wrap flag.
//  A stalled m_axis holds one word in the output register and one in stage A
//  before s_axis_tready drops. cfg_ready is always high.
module stereo_feedback_delay_line_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [15:0] left_in, [31:16] right_in
  input  logic [sfdl_pkg::FRAME_W-1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [15:0] left_out, [31:16] right_out
  output logic [sfdl_pkg::FRAME_W-1:0] m_axis_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sfdl_pkg::IDX_W-1:0]   cfg_index,
  input  logic [sfdl_pkg::CFG_W-1:0]   cfg_data
);

  localparam int AW = sfdl_pkg::ADDR_W;
  localparam int SW = sfdl_pkg::SAMPLE_W;
  localparam int CW = sfdl_pkg::CMP_W;
  localparam logic [AW-1:0] PTR_LAST  = AW'(sfdl_pkg::HIST_DEPTH - 1);
  localparam logic [CW-1:0] DLY_LIMIT = CW'(sfdl_pkg::HIST_DEPTH - 1);

  // configuration registers
  logic [sfdl_pkg::DELAY_W-1:0] delay_samples;
  logic [sfdl_pkg::GAIN_W-1:0]  feedback_gain;

  // write pointer and fill tracking
  logic [AW-1:0] wp;
  logic [AW-1:0] wp_next;
  logic          wrapped;

  // stage A: word waiting on RAM data / being computed
  logic                 a_valid;
  logic [SW-1:0]        a_x_l;
  logic [SW-1:0]        a_x_r;
  logic [AW-1:0]        a_wp;
  sfdl_pkg::chan_ctl_t  a_ctl;

  // output register and last write-back word
  logic                 out_valid;
  logic [2*SW-1:0]      out_data;
  logic [2*SW-1:0]      lw_data;

  logic                 in_acc;
  logic                 a_adv;
  logic [CW-1:0]        d_cmp;
  logic [AW-1:0]        d_cl;
  logic [AW-1:0]        rp;
  logic [sfdl_pkg::GAIN_W-1:0] g_cl;
  sfdl_pkg::chan_ctl_t  ctl_next;
  logic [2*SW-1:0]      rdata;
  logic [SW-1:0]        y_l;
  logic [SW-1:0]        y_r;

  assign cfg_ready     = 1'b1;
  assign a_adv         = a_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !a_valid || a_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  assign wp_next = (wp == PTR_LAST) ? '0 : wp + 1'b1;

  // tap address: delay clamped to depth - 1, wrapped behind the pointer
  always_comb begin
    d_cmp = CW'(delay_samples);
    if (d_cmp > DLY_LIMIT) begin
      d_cl = AW'(DLY_LIMIT);
    end else begin
      d_cl = AW'(d_cmp);
    end
    if (wp >= d_cl) begin
      rp = wp - d_cl;
    end else begin
      rp = AW'({1'b0, wp} + (AW + 1)'(sfdl_pkg::HIST_DEPTH) - {1'b0, d_cl});
    end
    g_cl = (feedback_gain > sfdl_pkg::GAIN_MAX) ? sfdl_pkg::GAIN_MAX : feedback_gain;
    ctl_next.d_zero   = (d_cl == '0);
    // previous word writes back at this very edge: RAM returns the stale word
    ctl_next.fwd_hit  = a_adv && (a_wp == rp);
    // before the first wrap only entries below the pointer hold data
    ctl_next.hist_vld = wrapped || (d_cl <= wp);
    ctl_next.gain     = g_cl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= sfdl_pkg::DELAY_RESET;
      feedback_gain <= sfdl_pkg::GAIN_RESET;
      wp            <= '0;
      wrapped       <= 1'b0;
      a_valid       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sfdl_pkg::REG_DELAY: delay_samples <= cfg_data[sfdl_pkg::DELAY_W-1:0];
          sfdl_pkg::REG_GAIN:  feedback_gain <= cfg_data[sfdl_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        wp <= wp_next;
        if (wp == PTR_LAST) begin
          wrapped <= 1'b1;
        end
      end
      if (in_acc) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
      if (a_adv) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_x_l <= s_axis_tdata[SW-1:0];
      a_x_r <= s_axis_tdata[2*SW-1:SW];
      a_wp  <= wp;
      a_ctl <= ctl_next;
    end
    if (a_adv) begin
      out_data <= {y_r, y_l};
      lw_data  <= {y_r, y_l};
    end
  end

  sfdl_ram #(
    .WIDTH (2 * SW),
    .DEPTH (sfdl_pkg::HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (a_adv),
    .waddr (a_wp),
    .wdata ({y_r, y_l}),
    .re    (in_acc),
    .raddr (rp),
    .rdata (rdata)
  );

  sfdl_chan u_left (
    .x     (a_x_l),
    .rdata (rdata[SW-1:0]),
    .fwd   (lw_data[SW-1:0]),
    .ctl   (a_ctl),
    .y     (y_l)
  );

  sfdl_chan u_right (
    .x     (a_x_r),
    .rdata (rdata[2*SW-1:SW]),
    .fwd   (lw_data[2*SW-1:SW]),
    .ctl   (a_ctl),
    .y     (y_r)
  );

  // forwarded word always targets an entry already written
  a_fwd_written: assert property (@(posedge clk) disable iff (rst)
    a_valid && a_ctl.fwd_hit |-> a_ctl.hist_vld)
    else $error("forwarding hit on unwritten history entry");

  // pointer steps by exactly one entry per accepted word
  a_wp_step: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (wp == $past(wp_next)) && (a_wp == $past(wp)))
    else $error("write pointer did not advance with accepted word");

  // once wrapped, the whole history is live until reset
  a_wrap_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(wrapped))
    else $error("wrap flag cleared outside reset");

  // a stalled stage A keeps its word
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_adv |=> a_valid && $stable(a_wp))
    else $error("stage A lost a word under stall");

endmodule
